// ----- rtl/sorted_leaf_search_insert_assert.svh -----
// assertion macros for the sorted leaf search and insert sequencer
`ifndef SORTED_LEAF_SEARCH_INSERT_ASSERT_SVH
`define SORTED_LEAF_SEARCH_INSERT_ASSERT_SVH

// same-cycle implication, held off while in reset
`define SLSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off while in reset
`define SLSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/slsi_pkg.sv -----
// types, sizes and codes for the sorted leaf search and insert block
`default_nettype none

package slsi_pkg;

  // table sizing
  localparam int MAX_ENTRIES = 16;
  localparam int VALUE_BITS  = 64;
  localparam int KEY_BITS    = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W     = KEY_BITS + VALUE_BITS;

  // fixed field widths on the ports
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 5;
  localparam int STATUS_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BEYOND = 2'd2;

  // input item
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [31:0]      search_key;
    logic [63:0]      entry_value;
    logic [SLOT_W-1:0] slot;
  } slsi_in_t;

  // result item
  typedef struct packed {
    logic [SLOT_W-1:0]   result_slot;
    logic                key_found;
    logic [SLOT_W-1:0]   entry_count;
    logic [STATUS_W-1:0] status;
  } slsi_out_t;

  // entry memory access from the sequencer
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } slsi_ram_req_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_SHIFT,
    ST_PUT,
    ST_DONE
  } slsi_state_t;

endpackage

`default_nettype wire

// ----- rtl/slsi_ram.sv -----
// simple dual-port entry memory, one write and one registered read per cycle
`default_nettype none

module slsi_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/slsi_ctrl.sv -----
// command sequencer: binary search probes, shift-up insert, clear
`default_nettype none

`include "sorted_leaf_search_insert_assert.svh"

module slsi_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  slsi_pkg::slsi_in_t              in_data,
  output slsi_pkg::slsi_ram_req_t         ram_req,
  input  logic [slsi_pkg::ENTRY_W-1:0]    ram_rdata,
  output logic                            res_valid,
  output slsi_pkg::slsi_out_t             res_data,
  input  logic                            res_take
);
  import slsi_pkg::*;

  slsi_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [CNT_W-1:0]      lo_r, lo_nxt;
  logic [CNT_W-1:0]      hi_r, hi_nxt;
  logic [IDX_W-1:0]      mid_r, mid_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [IDX_W-1:0]      wa_r, wa_nxt;
  logic                  pend_r, pend_nxt;
  logic [CNT_W-1:0]      slot_r, slot_nxt;
  logic                  found_r, found_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;

  logic [CNT_W:0]        mid_sum;
  logic [IDX_W-1:0]      mid;
  logic [KEY_BITS-1:0]   probe;

  // midpoint of the open search window and the key just read
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[IDX_W:1];
  assign probe   = ram_rdata[ENTRY_W-1 -: KEY_BITS];

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    i_r      <= i_nxt;
    wa_r     <= wa_nxt;
    slot_r   <= slot_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  // next state and memory access
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    i_nxt      = i_r;
    wa_nxt     = wa_r;
    pend_nxt   = pend_r;
    slot_nxt   = slot_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    ram_req    = '0;

    in_stall  = (state_r != ST_IDLE);
    res_valid = (state_r == ST_DONE);

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          key_nxt    = in_data.search_key;
          val_nxt    = in_data.entry_value[VALUE_BITS-1:0];
          slot_nxt   = '0;
          found_nxt  = 1'b0;
          status_nxt = STATUS_OK;
          pend_nxt   = 1'b0;
          case (in_data.cmd)
            CMD_FIND: begin
              lo_nxt    = '0;
              hi_nxt    = count_r;
              state_nxt = ST_FIND_RD;
            end
            CMD_INSERT: begin
              if (count_r >= CNT_W'(MAX_ENTRIES)) begin
                status_nxt = STATUS_FULL;
                state_nxt  = ST_DONE;
              end else if (int'(in_data.slot) > int'(count_r)) begin
                status_nxt = STATUS_BEYOND;
                state_nxt  = ST_DONE;
              end else begin
                pos_nxt   = CNT_W'(in_data.slot);
                i_nxt     = count_r;
                state_nxt = ST_SHIFT;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      // issue a probe read or finish on an empty window
      ST_FIND_RD: begin
        if (lo_r == hi_r) begin
          slot_nxt  = lo_r;
          state_nxt = ST_DONE;
        end else begin
          ram_req.raddr = mid;
          mid_nxt       = mid;
          state_nxt     = ST_FIND_CMP;
        end
      end

      // narrow the window on the probed key
      ST_FIND_CMP: begin
        if (key_r == probe) begin
          slot_nxt  = CNT_W'(mid_r);
          found_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          if (key_r < probe) begin
            hi_nxt = CNT_W'(mid_r);
          end else begin
            lo_nxt = CNT_W'(mid_r) + CNT_W'(1);
          end
          state_nxt = ST_FIND_RD;
        end
      end

      // move entries up one slot, read below while writing the last one read
      ST_SHIFT: begin
        if (pend_r) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = wa_r;
          ram_req.wdata = ram_rdata;
        end
        if (i_r > pos_r) begin
          ram_req.raddr = IDX_W'(i_r - CNT_W'(1));
          wa_nxt        = IDX_W'(i_r);
          i_nxt         = i_r - CNT_W'(1);
          pend_nxt      = 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_PUT;
        end
      end

      // write the new pair into the opened slot
      ST_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = IDX_W'(pos_r);
        ram_req.wdata = {key_r, val_r};
        count_nxt     = count_r + CNT_W'(1);
        slot_nxt      = pos_r;
        state_nxt     = ST_DONE;
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // result fields
  always_comb begin
    res_data.result_slot = SLOT_W'(slot_r);
    res_data.key_found   = found_r;
    res_data.entry_count = SLOT_W'(count_r);
    res_data.status      = status_r;
  end

  `SLSI_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_ENTRIES), "fill count above capacity")
  `SLSI_ASSERT_IMP(a_find_no_write, clk, rst_n, state_r == ST_FIND_RD || state_r == ST_FIND_CMP, !ram_req.we, "memory written during search")
  `SLSI_ASSERT_IMP(a_shift_above_pos, clk, rst_n, state_r == ST_SHIFT && ram_req.we, CNT_W'(ram_req.waddr) > pos_r, "shift write at or below insert slot")
  `SLSI_ASSERT_NXT(a_accept_busy, clk, rst_n, in_valid && !in_stall, state_r != ST_IDLE, "accepted item did not start")

endmodule

`default_nettype wire

// ----- rtl/sorted_leaf_search_insert.sv -----
// top level of the sorted leaf table with binary search and positional insert
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | cmd, search_key, entry_value, slot
//  out_    | output    | out_valid/out_stall| result_slot, key_found, entry_count, status
//
// one item at a time; the entry memory has one read and one write port
// find: a read state and a compare state per probe, up to log2(count)+1 probes
// insert: shift up from slot, one entry moved per cycle through the memory
// clear and rejected commands go straight to the result
// reset empties the table at once through the fill count; no clearing pass
// a stalled result sits in the output register while the next item is taken
`default_nettype none

module sorted_leaf_search_insert (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  slsi_pkg::slsi_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slsi_pkg::slsi_out_t out_data
);
  import slsi_pkg::*;

  slsi_ram_req_t      ram_req;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               res_valid;
  slsi_out_t          res_data;
  logic               res_take;
  logic               out_valid_r;
  slsi_out_t          out_data_r;

  // sequencer
  slsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_data  (res_data),
    .res_take  (res_take)
  );

  // key and value pairs, key in the upper bits
  slsi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // output register takes a result when empty or being drained
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// testbench for the sorted leaf table: find, insert and clear commands checked against a predictor
`timescale 1ns / 100ps

module tb;
  import slsi_pkg::*;

  // the one command code the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 50;
  localparam int PHASE_ITEMS = 135;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  slsi_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  slsi_out_t out_data;

  sorted_leaf_search_insert uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // command backlog and the keys it will leave in the table
  slsi_in_t    cmd_backlog[$];
  logic [31:0] plan_keys[$];

  // predicted leaf contents and the results still owed
  logic [31:0] leaf_keys[MAX_ENTRIES];
  int          leaf_count;
  slsi_out_t   owed_results[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_tag;
  int  hold_seen;
  int  hold_left;
  bit  in_took;
  bit  out_took;
  int  quiet_cycles;
  int  err_count;
  int  n_items;
  int  n_results;
  int  n_hits;
  int  n_full;
  int  n_beyond;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // apply one command to the predicted leaf and return the result it gives
  task automatic leaf_outcome(input slsi_in_t it, output slsi_out_t res);
    int lo;
    int hi;
    int mid;
    bit hit;
    res = '0;
    case (it.cmd)
      CMD_FIND: begin
        lo  = 0;
        hi  = leaf_count;
        hit = 1'b0;
        while (lo != hi && !hit) begin
          mid = (lo + hi) / 2;
          if (it.search_key == leaf_keys[mid]) begin
            res.result_slot = SLOT_W'(mid);
            res.key_found   = 1'b1;
            hit = 1'b1;
          end else if (it.search_key < leaf_keys[mid]) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        if (!hit) res.result_slot = SLOT_W'(lo);
      end
      CMD_INSERT: begin
        // full is checked before the slot range
        if (leaf_count >= MAX_ENTRIES) begin
          res.status = STATUS_FULL;
        end else if (int'(it.slot) > leaf_count) begin
          res.status = STATUS_BEYOND;
        end else begin
          for (int i = leaf_count; i > int'(it.slot); i--) leaf_keys[i] = leaf_keys[i-1];
          leaf_keys[it.slot] = it.search_key;
          leaf_count++;
          res.result_slot = it.slot;
        end
      end
      CMD_CLEAR: leaf_count = 0;
      default: ;
    endcase
    res.entry_count = SLOT_W'(leaf_count);
  endtask

  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      err_count++;
    end
  endtask

  // queue one command and track the keys it leaves behind
  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [31:0] key,
                           input logic [63:0] val, input logic [SLOT_W-1:0] slot);
    slsi_in_t it;
    it.cmd         = cmd;
    it.search_key  = key;
    it.entry_value = val;
    it.slot        = slot;
    if (cmd == CMD_INSERT && plan_keys.size() < MAX_ENTRIES && int'(slot) <= plan_keys.size())
      plan_keys.insert(int'(slot), key);
    else if (cmd == CMD_CLEAR)
      plan_keys.delete();
    cmd_backlog.push_back(it);
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r == 2) return 32'($urandom_range(63));
    if (r <= 5 && plan_keys.size() != 0) return plan_keys[$urandom_range(plan_keys.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic [63:0] pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 64'h0;
    if (r == 1) return {64{1'b1}};
    return {$urandom, $urandom};
  endfunction

  // mostly well-formed finds and inserts, with some clears and broken commands
  task automatic push_random();
    int r;
    int n;
    int pos;
    logic [31:0] key;
    r = $urandom_range(99);
    n = plan_keys.size();
    if (r < 2) begin
      push_item(CMD_CLEAR, $urandom, pick_value(), 5'($urandom_range(31)));
    end else if (r < 6) begin
      push_item(CMD_UNUSED, $urandom, pick_value(), 5'($urandom_range(31)));
    end else if (r < 10) begin
      // out of order insert at any legal slot
      pos = (n < MAX_ENTRIES) ? $urandom_range(n) : $urandom_range(31);
      push_item(CMD_INSERT, pick_key(), pick_value(), 5'(pos));
    end else if (r < 14) begin
      // slot past the count
      pos = (n < MAX_ENTRIES) ? $urandom_range(31, n + 1) : $urandom_range(31);
      push_item(CMD_INSERT, pick_key(), pick_value(), 5'(pos));
    end else if (r < 55) begin
      push_item(CMD_FIND, pick_key(), pick_value(), 5'($urandom_range(31)));
    end else begin
      // in-order insert at the lower bound of the key
      key = pick_key();
      pos = 0;
      foreach (plan_keys[i]) if (plan_keys[i] < key) pos++;
      push_item(CMD_INSERT, key, pick_value(), 5'(pos));
    end
  endtask

  // wait for every command to finish, then let the block settle
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // driver: a new item goes out once the previous one is taken
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= cmd_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_tag != hold_seen) begin
        hold_seen = hold_tag;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // monitor: check results in order, then predict the item taken
  always @(posedge clk) begin
    slsi_out_t exp_r;
    slsi_out_t pred;
    if (!rst_n) begin
      in_took  = 1'b0;
      out_took = 1'b0;
    end else begin
      in_took  = in_valid && !in_stall;
      out_took = out_valid && !out_stall;
      if (out_took) begin
        n_results++;
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          err_count++;
        end else begin
          exp_r = owed_results.pop_front();
          check_field("result_slot", int'(exp_r.result_slot), int'(out_data.result_slot));
          check_field("key_found", int'(exp_r.key_found), int'(out_data.key_found));
          check_field("entry_count", int'(exp_r.entry_count), int'(out_data.entry_count));
          check_field("status", int'(exp_r.status), int'(out_data.status));
          if (exp_r.key_found) n_hits++;
          if (exp_r.status == STATUS_FULL) n_full++;
          if (exp_r.status == STATUS_BEYOND) n_beyond++;
        end
      end
      if (in_took) begin
        leaf_outcome(in_data, pred);
        owed_results.push_back(pred);
        n_items++;
      end
      quiet_cycles = (in_took || out_took) ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus and end of run
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    leaf_count    = 0;
    hold_tag      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    quiet_cycles  = 0;
    err_count     = 0;
    n_items       = 0;
    n_results     = 0;
    n_hits        = 0;
    n_full        = 0;
    n_beyond      = 0;
    send_idle_pct = 16;
    recv_idle_pct = 76;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, fill to full, full cases, clear
    push_item(CMD_FIND, 32'h0, 64'h0, 5'd0);
    push_item(CMD_INSERT, 32'h5, 64'h1, 5'd1);
    push_item(CMD_UNUSED, 32'hFFFF_FFFF, {64{1'b1}}, 5'd31);
    push_item(CMD_INSERT, 32'hFFFF_FFFF, {64{1'b1}}, 5'd0);
    push_item(CMD_INSERT, 32'h0, 64'h0, 5'd0);
    for (int i = 1; i <= MAX_ENTRIES - 2; i++)
      push_item(CMD_INSERT, 32'(100 * i), {$urandom, $urandom}, 5'(i));
    push_item(CMD_INSERT, 32'h1234, 64'h2, 5'd3);
    push_item(CMD_INSERT, 32'h1235, 64'h3, 5'd31);
    push_item(CMD_FIND, 32'hFFFF_FFFF, 64'h0, 5'd0);
    push_item(CMD_FIND, 32'h0, 64'h0, 5'd0);
    push_item(CMD_FIND, 32'd150, 64'h0, 5'd0);
    push_item(CMD_CLEAR, 32'h0, 64'h0, 5'd0);
    push_item(CMD_FIND, 32'hFFFF_FFFF, 64'h0, 5'd0);
    drain();

    // sender mostly busy, receiver mostly stalling
    repeat (PHASE_ITEMS) push_random();
    drain();

    // the other way round
    send_idle_pct = 76;
    recv_idle_pct = 16;
    repeat (PHASE_ITEMS) push_random();
    drain();

    // no idling, opened by a long receiver hold-off so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_tag++;
    repeat (PHASE_ITEMS) push_random();
    drain();

    $display("ran %0d commands and checked %0d results", n_items, n_results);
    $display("%0d find hits, %0d inserts into a full table, %0d past the count",
             n_hits, n_full, n_beyond);
    if (owed_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, owed_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/slsi_pkg.sv
rtl/slsi_ram.sv
rtl/slsi_ctrl.sv
rtl/sorted_leaf_search_insert.sv
tb/tb.sv
